// ===== hdl/abd_pkg.sv =====
// ----------------------------------------------------------------------------
// abd_pkg
// Shared widths, register indexes, limits and the activity function of the
// activity burst detector.
// ----------------------------------------------------------------------------
package abd_pkg;

  localparam int BYTE_W      = 8;
  localparam int ACT_W       = 7;
  localparam int RATIO_W     = 10;
  localparam int FLOOR_W     = 7;
  localparam int COOL_W      = 12;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_INDEX_W = 2;

  localparam int DEF_HISTORY_DEPTH = 60;
  localparam int DEF_WARMUP_TICKS  = 60;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SPIKE_RATIO    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVITY_FLOOR = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COOLDOWN_TICKS = 2'd2;

  localparam logic [RATIO_W-1:0] RATIO_LOW   = 10'd110;
  localparam logic [RATIO_W-1:0] RATIO_HIGH  = 10'd1000;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 10'd250;
  localparam logic [FLOOR_W-1:0] FLOOR_LOW   = 7'd1;
  localparam logic [FLOOR_W-1:0] FLOOR_HIGH  = 7'd100;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = 7'd25;
  localparam logic [COOL_W-1:0]  COOL_LOW    = 12'd1;
  localparam logic [COOL_W-1:0]  COOL_HIGH   = 12'd3600;
  localparam logic [COOL_W-1:0]  COOL_RESET  = 12'd5;

  localparam logic [ACT_W-1:0] ACTIVITY_MAX = 7'd100;
  localparam logic [ACT_W-1:0] PCT_SCALE    = 7'd100;

  // Request from the pipeline to the history store
  typedef struct packed {
    logic             rd;      // item accepted: read the oldest entry
    logic             wr;      // item leaves stage one: replace that entry
    logic [ACT_W-1:0] wr_act;
  } abd_hist_req_t;

  // activity = min(100, |dropped| + (|spread| >> 1))
  function automatic logic [ACT_W-1:0] activity(input logic [BYTE_W-1:0] spread,
                                                input logic [BYTE_W-1:0] dropped);
    logic [BYTE_W-1:0] mag_s;
    logic [BYTE_W-1:0] mag_d;
    logic [BYTE_W:0]   total;
    mag_s = spread[BYTE_W-1] ? BYTE_W'(~spread + 8'd1) : spread;
    mag_d = dropped[BYTE_W-1] ? BYTE_W'(~dropped + 8'd1) : dropped;
    total = {1'b0, mag_d} + {2'b00, mag_s[BYTE_W-1:1]};
    if (total > (BYTE_W+1)'(ACTIVITY_MAX)) begin
      return ACTIVITY_MAX;
    end
    return total[ACT_W-1:0];
  endfunction

endpackage

// ===== hdl/abd_history.sv =====
// ----------------------------------------------------------------------------
// abd_history
// Ring of past activity values in a synchronous RAM, with its running sum.
// ----------------------------------------------------------------------------
module abd_history import abd_pkg::*; #(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int SUM_W         = 13
) (
  input  logic                clk,
  input  logic                rst,
  input  abd_hist_req_t       req,
  output logic [SUM_W-1:0]    sum
);

  localparam int ADDR_W = $clog2(HISTORY_DEPTH);
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(HISTORY_DEPTH - 1);

  logic [ACT_W-1:0]  mem [HISTORY_DEPTH];
  logic [ACT_W-1:0]  rdata;
  logic [ADDR_W-1:0] head;
  logic [ADDR_W-1:0] wr_addr;
  logic              wrapped;
  logic              rd_live;
  logic              pending;
  logic [ACT_W-1:0]  old_act;
  logic [SUM_W-1:0]  sum_next;

  // RAM: read old entry on accept, write the new one on its write request
  always_ff @(posedge clk) begin
    if (req.rd) begin
      rdata <= mem[head];
    end
    if (req.wr) begin
      mem[wr_addr] <= req.wr_act;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      wr_addr <= head;
      rd_live <= wrapped;
    end
  end

  // Entries fill in address order, so before the first wrap the head entry
  // has never been written and counts as zero.
  assign old_act  = rd_live ? rdata : '0;
  assign sum_next = sum - SUM_W'(old_act) + SUM_W'(req.wr_act);

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      wrapped <= 1'b0;
      sum     <= '0;
      pending <= 1'b0;
    end else begin
      if (req.rd) begin
        if (head == LAST) begin
          head    <= '0;
          wrapped <= 1'b1;
        end else begin
          head <= head + 1'b1;
        end
      end
      if (req.wr) begin
        sum <= sum_next;
      end
      if (req.rd) begin
        pending <= 1'b1;
      end else if (req.wr) begin
        pending <= 1'b0;
      end
    end
  end

  a_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    req.wr |-> pending) else $error("history write without a read");

  a_one_open: assert property (@(posedge clk) disable iff (rst)
    (req.rd && !req.wr) |-> !pending) else $error("two history reads open");

  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    sum <= SUM_W'(HISTORY_DEPTH * 100)) else $error("history sum out of range");

endmodule

// ===== hdl/activity_burst_detector.sv =====
// ----------------------------------------------------------------------------
// activity_burst_detector
// Folds RSSI spread and dropped frames into an activity value and reports
// bursts above a rolling average, with a floor and a cooldown.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle when the output side keeps up, and
// a burst result is loaded into the output register after the last stage.
// The pipeline is four stages: accept and history RAM read, running-sum
// update and RAM write-back, average by reciprocal multiply, then ratio
// multiply, followed by the compare and cooldown update that load the
// output register. Stages hold when the output register is full and not
// taken, so new items are still accepted until the bubbles are used up. The
// history starts empty after reset with no clearing pass; the first
// WARMUP_TICKS items only fill the history and give no result. Configuration
// writes are clamped to each register's range and unknown indexes are
// dropped; write them only while no item is in flight.
module activity_burst_detector import abd_pkg::*; #(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int WARMUP_TICKS  = DEF_WARMUP_TICKS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [BYTE_W-1:0] rssi_spread,
  input  logic signed [BYTE_W-1:0] frames_dropped,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ACT_W-1:0]         burst_intensity
);

  // Sum of the whole ring and exact divide by HISTORY_DEPTH through a
  // rounded-up reciprocal: floor(sum * RECIP / 2^SHIFT) == floor(sum / D)
  localparam int SUM_W   = $clog2(HISTORY_DEPTH * 100 + 1);
  localparam int LOG_D   = $clog2(HISTORY_DEPTH);
  localparam int SHIFT   = SUM_W + LOG_D;
  localparam int RECIP_W = SUM_W + 1;
  localparam int RECIP   = ((1 << SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam int MUL_W   = ACT_W + RATIO_W;
  localparam int WARM_W  = $clog2(WARMUP_TICKS + 1);

  // Configuration registers
  logic [RATIO_W-1:0] spike_ratio_percent;
  logic [FLOOR_W-1:0] activity_floor;
  logic [COOL_W-1:0]  cooldown_ticks;

  // Detector state outside the RAM
  logic [WARM_W-1:0]  warmup_left;
  logic [COOL_W-1:0]  cooldown_left;
  logic [COOL_W-1:0]  cool_dec;
  logic               hit;

  // Pipeline stages
  logic               v1, v2, v3, v4;
  logic               go1, go2, go3, go4;
  logic               rdy1, rdy2, rdy3, rdy4;
  logic               accept;
  logic [ACT_W-1:0]   act1, act2, act3, act4;
  logic               warm1, warm2, warm3, warm4;
  logic [SUM_W-1:0]   sum2;
  logic [PROD_W-1:0]  prod3;
  logic [ACT_W-1:0]   avg3;
  logic [MUL_W-1:0]   lhs4, rhs4;

  logic [SUM_W-1:0]   hist_sum;
  abd_hist_req_t      hist_req;

  function automatic logic [CFG_DATA_W-1:0] clamp_cfg(input logic [CFG_DATA_W-1:0] v,
                                                      input logic [CFG_DATA_W-1:0] lo,
                                                      input logic [CFG_DATA_W-1:0] hi);
    if (v < lo) begin
      return lo;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  // Clamp and store configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      spike_ratio_percent <= RATIO_RESET;
      activity_floor      <= FLOOR_RESET;
      cooldown_ticks      <= COOL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SPIKE_RATIO: begin
          spike_ratio_percent <= RATIO_W'(clamp_cfg(cfg_data,
            CFG_DATA_W'(RATIO_LOW), CFG_DATA_W'(RATIO_HIGH)));
        end
        REG_ACTIVITY_FLOOR: begin
          activity_floor <= FLOOR_W'(clamp_cfg(cfg_data,
            CFG_DATA_W'(FLOOR_LOW), CFG_DATA_W'(FLOOR_HIGH)));
        end
        REG_COOLDOWN_TICKS: begin
          cooldown_ticks <= COOL_W'(clamp_cfg(cfg_data,
            CFG_DATA_W'(COOL_LOW), CFG_DATA_W'(COOL_HIGH)));
        end
        default: begin
        end
      endcase
    end
  end

  // Elastic flow: a stage advances when the one after it is empty or moving
  assign rdy4     = !out_valid || out_ready;
  assign go4      = v4 && rdy4;
  assign rdy3     = !v4 || rdy4;
  assign go3      = v3 && rdy3;
  assign rdy2     = !v3 || rdy3;
  assign go2      = v2 && rdy2;
  assign rdy1     = !v2 || rdy2;
  assign go1      = v1 && rdy1;
  assign in_ready = !v1 || rdy1;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (accept) begin
        v1 <= 1'b1;
      end else if (go1) begin
        v1 <= 1'b0;
      end
      if (go1) begin
        v2 <= 1'b1;
      end else if (go2) begin
        v2 <= 1'b0;
      end
      if (go2) begin
        v3 <= 1'b1;
      end else if (go3) begin
        v3 <= 1'b0;
      end
      if (go3) begin
        v4 <= 1'b1;
      end else if (go4) begin
        v4 <= 1'b0;
      end
    end
  end

  // Warmup counts accepted items; the flag rides along with the item
  always_ff @(posedge clk) begin
    if (rst) begin
      warmup_left <= WARM_W'(WARMUP_TICKS);
    end else if (accept && warmup_left != '0) begin
      warmup_left <= warmup_left - 1'b1;
    end
  end

  // Stage 1: activity and history RAM read
  always_ff @(posedge clk) begin
    if (accept) begin
      act1  <= activity(rssi_spread, frames_dropped);
      warm1 <= (warmup_left != '0);
    end
  end

  assign hist_req.rd     = accept;
  assign hist_req.wr     = go1;
  assign hist_req.wr_act = act1;

  abd_history #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SUM_W         (SUM_W)
  ) u_history (
    .clk (clk),
    .rst (rst),
    .req (hist_req),
    .sum (hist_sum)
  );

  // Stage 2: capture the sum before this item's own append
  always_ff @(posedge clk) begin
    if (go1) begin
      act2  <= act1;
      warm2 <= warm1;
      sum2  <= hist_sum;
    end
  end

  // Stage 3: sum times reciprocal
  always_ff @(posedge clk) begin
    if (go2) begin
      act3  <= act2;
      warm3 <= warm2;
      prod3 <= PROD_W'(sum2) * PROD_W'(RECIP);
    end
  end

  assign avg3 = prod3[SHIFT +: ACT_W];

  // Stage 4: both sides of the ratio test
  always_ff @(posedge clk) begin
    if (go3) begin
      act4  <= act3;
      warm4 <= warm3;
      lhs4  <= MUL_W'(act3) * MUL_W'(PCT_SCALE);
      rhs4  <= MUL_W'(avg3) * MUL_W'(spike_ratio_percent);
    end
  end

  // Cooldown counts every item, warmup included, before the test
  assign cool_dec = (cooldown_left != '0) ? cooldown_left - 1'b1 : '0;
  assign hit      = !warm4 && (cool_dec == '0) && (act4 >= activity_floor) &&
                    (lhs4 >= rhs4);

  always_ff @(posedge clk) begin
    if (rst) begin
      cooldown_left <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (go4) begin
        cooldown_left <= hit ? cooldown_ticks : cool_dec;
        if (hit) begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go4 && hit) begin
      burst_intensity <= act4;
    end
  end

  a_reload: assert property (@(posedge clk) disable iff (rst)
    (go4 && hit) |=> cooldown_left == cooldown_ticks)
    else $error("cooldown not reloaded after a burst");

  a_quiet_warmup: assert property (@(posedge clk) disable iff (rst)
    (warmup_left != '0) |-> !out_valid)
    else $error("burst reported during warmup");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (burst_intensity != '0 && burst_intensity <= ACTIVITY_MAX))
    else $error("burst intensity out of range");

  a_cool_range: assert property (@(posedge clk) disable iff (rst)
    cooldown_left <= COOL_HIGH)
    else $error("cooldown counter out of range");

endmodule

// ===== test/tb_activity_burst_detector.sv =====
// ----------------------------------------------------------------------------
// tb_activity_burst_detector
// Self-checking testbench for the activity burst detector. A scoreboard
// predicts the burst for every accepted item and matches each delivered
// burst against the oldest prediction. The run covers reset and clamped
// register settings, with random idling on both the input and output sides.
// ----------------------------------------------------------------------------
module tb_activity_burst_detector;
  timeunit 1ns;
  timeprecision 1ps;

  import abd_pkg::*;

  // Index with no register behind it; writes to it must change nothing
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  // Scoreboard: own copy of the detector state, plus the bursts still owed
  class burst_scoreboard;
    int unsigned      ratio_pct;
    int unsigned      act_floor;
    int unsigned      cool_ticks;
    logic [ACT_W-1:0] history [DEF_HISTORY_DEPTH];
    int unsigned      head;
    int unsigned      hist_sum;
    int unsigned      warm_left;
    int unsigned      cool_left;
    logic [ACT_W-1:0] burst_queue [$];
    int unsigned      errors;

    function new();
      ratio_pct  = 32'(RATIO_RESET);
      act_floor  = 32'(FLOOR_RESET);
      cool_ticks = 32'(COOL_RESET);
      foreach (history[i]) history[i] = '0;
      head       = 0;
      hist_sum   = 0;
      warm_left  = DEF_WARMUP_TICKS;
      cool_left  = 0;
      errors     = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SPIKE_RATIO:
          ratio_pct  = clamp(32'(data), 32'(RATIO_LOW), 32'(RATIO_HIGH));
        REG_ACTIVITY_FLOOR:
          act_floor  = clamp(32'(data), 32'(FLOOR_LOW), 32'(FLOOR_HIGH));
        REG_COOLDOWN_TICKS:
          cool_ticks = clamp(32'(data), 32'(COOL_LOW), 32'(COOL_HIGH));
        default: ;
      endcase
    endfunction

    // Predict the outcome of one accepted tick
    function void note_tick(logic [BYTE_W-1:0] spread, logic [BYTE_W-1:0] dropped);
      int unsigned mag_s;
      int unsigned mag_d;
      int unsigned act;
      int unsigned avg;
      mag_s = spread[BYTE_W-1] ? 256 - 32'(spread) : 32'(spread);
      mag_d = dropped[BYTE_W-1] ? 256 - 32'(dropped) : 32'(dropped);
      act   = mag_d + (mag_s >> 1);
      if (act > 32'(ACTIVITY_MAX)) act = 32'(ACTIVITY_MAX);
      if (cool_left > 0) cool_left--;
      if (warm_left > 0) begin
        warm_left--;
      end else begin
        // average over the whole ring, taken before this tick is appended
        avg = hist_sum / DEF_HISTORY_DEPTH;
        if (cool_left == 0 && act >= act_floor && act * 100 >= avg * ratio_pct) begin
          burst_queue.push_back(ACT_W'(act));
          cool_left = cool_ticks;
        end
      end
      hist_sum      = hist_sum - 32'(history[head]) + act;
      history[head] = ACT_W'(act);
      head          = (head + 1) % DEF_HISTORY_DEPTH;
    endfunction

    function void report(string what, int unsigned exp_val, int unsigned act_val);
      errors++;
      if (errors <= 10)
        $display("[%0t] %s: expected %0d, got %0d", $realtime, what, exp_val, act_val);
    endfunction

    function void check_burst(logic [ACT_W-1:0] actual);
      logic [ACT_W-1:0] exp_val;
      if (burst_queue.size() == 0) begin
        report("burst with none pending", 0, 32'(actual));
      end else begin
        exp_val = burst_queue.pop_front();
        if (exp_val !== actual)
          report("burst_intensity mismatch", 32'(exp_val), 32'(actual));
      end
    endfunction

    function int unsigned pending();
      return burst_queue.size();
    endfunction
  endclass

  // Every input starts at a known value
  logic                     clk            = 1'b0;
  logic                     rst            = 1'b1;
  logic                     cfg_write      = 1'b0;
  logic [CFG_INDEX_W-1:0]   cfg_index      = '0;
  logic [CFG_DATA_W-1:0]    cfg_data       = '0;
  logic                     in_valid       = 1'b0;
  logic                     in_ready;
  logic signed [BYTE_W-1:0] rssi_spread    = '0;
  logic signed [BYTE_W-1:0] frames_dropped = '0;
  logic                     out_valid;
  logic                     out_ready      = 1'b1;
  logic [ACT_W-1:0]         burst_intensity;

  burst_scoreboard sb;
  bit              calm         = 1'b0;  // no idling on either side
  bit              hold_request = 1'b0;  // ask the receiver for a long hold-off

  activity_burst_detector #(
    .HISTORY_DEPTH(DEF_HISTORY_DEPTH),
    .WARMUP_TICKS (DEF_WARMUP_TICKS)
  ) u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rssi_spread    (rssi_spread),
    .frames_dropped (frames_dropped),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .burst_intensity(burst_intensity)
  );

  always #5 clk = ~clk;

  // Hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Byte of the given magnitude with a random sign
  function automatic logic [BYTE_W-1:0] signed_byte(int unsigned mag);
    return $urandom_range(0, 1) ? BYTE_W'(0 - mag) : BYTE_W'(mag);
  endfunction

  // Offer one item and hold it until the block takes it. Called at a rising
  // edge; returns at the edge of acceptance without touching in_valid, so the
  // next call can keep it high.
  task automatic send_item(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] d);
    if (!calm && $urandom_range(0, 3) == 0) begin
      // drop valid for a random gap
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    rssi_spread    <= s;
    frames_dropped <= d;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(s, d);
  endtask

  // Mostly a quiet background with occasional spikes, so that the rolling
  // average stays low enough for bursts to fire; some raw noise on top.
  task automatic send_random();
    int unsigned      mode;
    logic [BYTE_W-1:0] s;
    logic [BYTE_W-1:0] d;
    mode = $urandom_range(0, 99);
    if (mode < 60) begin
      s = signed_byte($urandom_range(0, 24));
      d = signed_byte($urandom_range(0, 6));
    end else if (mode < 75) begin
      s = signed_byte($urandom_range(0, 80));
      d = signed_byte($urandom_range(0, 40));
    end else if (mode < 90) begin
      s = BYTE_W'($urandom);
      d = signed_byte($urandom_range(20, 128));
    end else begin
      s = BYTE_W'($urandom);
      d = BYTE_W'($urandom);
    end
    send_item(s, d);
  endtask

  // Leaves cfg_write high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Pause the sender until every owed burst is out, let items that give no
  // burst run through the pipeline, then write all registers.
  task automatic reconfigure(input logic [CFG_DATA_W-1:0] ratio,
                             input logic [CFG_DATA_W-1:0] floor_val,
                             input logic [CFG_DATA_W-1:0] cool);
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (10) @(posedge clk);
    write_reg(REG_SPIKE_RATIO, ratio);
    write_reg(REG_ACTIVITY_FLOOR, floor_val);
    write_reg(REG_COOLDOWN_TICKS, cool);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_write <= 1'b0;
  endtask

  // Receiver: check every delivered burst, stall in random bursts, and hold
  // off for a long stretch on request so the pipeline backs up.
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_burst(burst_intensity);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = 300;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Warmup with reset settings: extremes first, nothing may come out
    send_item(8'h80, 8'h80);
    send_item(8'h7f, 8'h7f);
    send_item(8'h00, 8'h00);
    repeat (DEF_WARMUP_TICKS - 3) send_random();

    // Directed: saturation, most negative bytes, floor edge, cooldown
    send_item(8'h00, 8'h00);
    send_item(8'h80, 8'h80);   // 128 + 64, saturates
    send_item(8'h7f, 8'h7f);   // inside cooldown
    send_item(8'h80, 8'h00);   // spread alone, 64
    send_item(8'h00, 8'h80);   // dropped alone, 128 saturates
    send_item(8'h7f, 8'h00);
    send_item(8'h00, 8'h7f);
    send_item(8'h01, 8'h01);
    send_item(8'hff, 8'hff);   // minus one both
    send_item(8'h00, 8'd24);   // just under the floor
    send_item(8'h00, 8'd25);   // exactly the floor
    send_item(8'h00, 8'd0);
    send_item(8'h00, 8'd0);
    send_item(8'h00, 8'd0);
    send_item(8'h00, 8'd0);
    send_item(8'h00, 8'd0);
    send_item(8'h00, 8'd25);   // cooldown over
    send_item(8'hce, 8'he7);   // -50, -25
    send_item(8'h81, 8'h9c);   // -127, -100
    send_item(8'h02, 8'h00);
    repeat (300) send_random();

    // Writes below range clamp to the low ends; bursts then fire almost every
    // tick, so a long hold-off leaves one waiting and backs up the pipeline
    reconfigure('0, '0, '0);
    hold_request = 1'b1;
    repeat (300) send_random();

    // Writes above range: ratio and floor clamp to their top ends
    reconfigure(12'd1023, 12'd127, 12'd2);
    repeat (300) send_random();

    // In-range random settings
    reconfigure(CFG_DATA_W'($urandom_range(RATIO_LOW, RATIO_HIGH)),
                CFG_DATA_W'($urandom_range(FLOOR_LOW, FLOOR_HIGH)),
                CFG_DATA_W'($urandom_range(1, 20)));
    repeat (300) send_random();

    // Raw random write data, short cooldown so bursts keep coming
    reconfigure(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                CFG_DATA_W'($urandom_range(0, 8)));
    repeat (300) send_random();

    // Exact range ends
    reconfigure(CFG_DATA_W'(RATIO_HIGH), CFG_DATA_W'(FLOOR_LOW), CFG_DATA_W'(COOL_LOW));
    repeat (300) send_random();

    // Last part at full rate: longest cooldown, no idling anywhere
    reconfigure(12'hfff, CFG_DATA_W'(FLOOR_RESET), 12'hfff);
    calm = 1'b1;
    repeat (100) send_random();

    // Drain, then watch for stray bursts a while longer
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== activity_burst_detector.f =====
hdl/abd_pkg.sv
hdl/abd_history.sv
hdl/activity_burst_detector.sv
test/tb_activity_burst_detector.sv
